/* rtl/core/gps_pkg.sv */
package gps_pkg;

	// fixed geometry of the block
	localparam int TABLE_DEPTH = 64;
	localparam int PIN_WIDTH   = 16;
	localparam int DELAY_WIDTH = 16;
	localparam int CFG_W       = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int NE_W        = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W     = 2 * DELAY_WIDTH + PIN_WIDTH;
	localparam int ADDR_W      = 4;

	// register map, index = paddr[3:2]
	localparam logic [1:0] REG_CYCLE_LIMIT    = 2'd0;
	localparam logic [1:0] REG_MAIN_PRESCALER = 2'd1;
	localparam logic [1:0] REG_MAIN_COUNT     = 2'd2;
	localparam logic [1:0] REG_IDLE_PINS      = 2'd3;

	typedef enum logic [2:0] {
		MODE_TICK  = 3'd0,
		MODE_START = 3'd1,
		MODE_STOP  = 3'd2,
		MODE_WRITE = 3'd3,
		MODE_RESET = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ERR_OK          = 3'd0,
		ERR_TOO_FAST    = 3'd1,
		ERR_NOT_STOPPED = 3'd2,
		ERR_NO_DATA     = 3'd3,
		ERR_NOT_STARTED = 3'd4,
		ERR_BUSY        = 3'd5,
		ERR_OVERFLOW    = 3'd6
	} err_t;

	typedef struct packed {
		logic [2:0]             mode;
		logic [IDX_W-1:0]       entry_index;
		logic [DELAY_WIDTH-1:0] entry_prescaler;
		logic [DELAY_WIDTH-1:0] entry_count;
		logic [PIN_WIDTH-1:0]   entry_pins;
		logic                   entry_last;
	} item_t;

	typedef struct packed {
		logic [PIN_WIDTH-1:0] pins;
		logic                 running;
		logic [2:0]           error_code;
		logic                 command_ok;
		logic [NE_W-1:0]      step_index;
	} result_t;

	typedef struct packed {
		logic [DELAY_WIDTH-1:0] pre;
		logic [DELAY_WIDTH-1:0] cnt;
		logic [PIN_WIDTH-1:0]   pat;
	} entry_t;

	typedef struct packed {
		logic [CFG_W-1:0]     cycle_limit;
		logic [CFG_W-1:0]     main_prescaler;
		logic [CFG_W-1:0]     main_count;
		logic [PIN_WIDTH-1:0] idle_pins;
	} cfg_t;

	// table access request from the sequencer core
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             clr;
		logic [IDX_W-1:0] rd_addr;
	} tbl_req_t;

endpackage

/* rtl/core/gps_ram.sv */
module gps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/gps_table.sv */
module gps_table (
	input  logic             clk,
	input  logic             arst_n,
	input  gps_pkg::tbl_req_t req,
	output gps_pkg::entry_t   entry
);
	import gps_pkg::*;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   rd_valid_q;
	logic                   byp_hit_q;
	entry_t                 byp_data_q;
	logic [ENTRY_W-1:0]     ram_rdata;
	logic                   hit;

	gps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (req.wr_en),
		.waddr(req.wr_addr),
		.wdata(req.wr_data),
		.raddr(req.rd_addr),
		.rdata(ram_rdata)
	);

	assign hit = req.wr_en && (req.wr_addr == req.rd_addr);

	// per-entry valid bits: cleared by reset and the reset command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			byp_hit_q  <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			rd_valid_q <= !req.clr && (hit || valid_q[req.rd_addr]);
			byp_hit_q  <= hit;
		end
	end

	// write data forwarded when it lands on the entry being fetched
	always_ff @(posedge clk) begin
		byp_data_q <= req.wr_data;
	end

	always_comb begin
		if (!rd_valid_q) begin
			entry = '0;
		end else if (byp_hit_q) begin
			entry = byp_data_q;
		end else begin
			entry = entry_t'(ram_rdata);
		end
	end

endmodule

/* rtl/core/gps_core.sv */
module gps_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  gps_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output gps_pkg::result_t result,
	input  gps_pkg::cfg_t    cfg,
	input  gps_pkg::entry_t  entry,
	output gps_pkg::tbl_req_t req
);
	import gps_pkg::*;

	typedef struct packed {
		logic [NE_W-1:0]        tlen;
		logic [NE_W-1:0]        ne;
		logic                   active;
		logic [CFG_W-1:0]       plft;
		logic [CFG_W-1:0]       mpc;
		logic [CFG_W-1:0]       mcc;
		logic [DELAY_WIDTH-1:0] spc;
		logic [DELAY_WIDTH-1:0] scc;
		logic                   step_on;
		logic [PIN_WIDTH-1:0]   pins;
		err_t                   err;
	} st_t;

	// stop generation, park the pins at the idle pattern
	function automatic st_t halt_st(st_t s, err_t e, logic [PIN_WIDTH-1:0] idle);
		st_t r;
		r         = s;
		r.step_on = 1'b0;
		r.active  = 1'b0;
		r.ne      = '0;
		r.plft    = '0;
		r.mpc     = '0;
		r.mcc     = '0;
		r.spc     = '0;
		r.scc     = '0;
		r.err     = e;
		r.pins    = idle;
		return r;
	endfunction

	st_t     st_q;
	st_t     nx;
	logic    ok;
	logic    acc;
	logic    mfire;
	logic    sfire;
	logic    sguard;
	logic    result_valid_q;
	result_t result_q;

	assign item_stall   = result_valid_q && result_stall;
	assign acc          = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// next state for the accepted item
	always_comb begin
		nx          = st_q;
		ok          = 1'b0;
		mfire       = 1'b0;
		sfire       = 1'b0;
		sguard      = 1'b0;
		req.wr_en   = 1'b0;
		req.wr_addr = item.entry_index;
		req.wr_data = '{pre: item.entry_prescaler, cnt: item.entry_count,
			pat: item.entry_pins};
		req.clr     = 1'b0;
		if (acc) begin
			unique case (item.mode)
				MODE_TICK: begin
					ok = 1'b1;
					if (st_q.active) begin
						// main period timer
						if (st_q.mpc >= cfg.main_prescaler) begin
							nx.mpc = '0;
							if (st_q.mcc >= cfg.main_count) begin
								nx.mcc = '0;
								mfire  = 1'b1;
							end else begin
								nx.mcc = st_q.mcc + 1'b1;
							end
						end else begin
							nx.mpc = st_q.mpc + 1'b1;
						end
						// step timer of the current entry
						sguard = st_q.step_on && (st_q.ne < st_q.tlen)
							&& (st_q.ne < NE_W'(TABLE_DEPTH));
						if (sguard) begin
							if (st_q.spc >= entry.pre) begin
								nx.spc = '0;
								if (st_q.scc >= entry.cnt) begin
									nx.scc = '0;
									sfire  = 1'b1;
								end else begin
									nx.scc = st_q.scc + 1'b1;
								end
							end else begin
								nx.spc = st_q.spc + 1'b1;
							end
						end
						// main firing wins over a step firing on the same tick
						if (mfire) begin
							if (st_q.ne < st_q.tlen) begin
								nx = halt_st(nx, ERR_TOO_FAST, cfg.idle_pins);
							end else if ((cfg.cycle_limit != '0) && (st_q.plft == '0)) begin
								nx = halt_st(nx, ERR_OK, cfg.idle_pins);
							end else begin
								nx.pins = cfg.idle_pins;
								nx.ne   = '0;
								if (cfg.cycle_limit != '0) begin
									nx.plft = st_q.plft - 1'b1;
								end
								nx.spc     = '0;
								nx.scc     = '0;
								nx.step_on = 1'b1;
							end
						end else if (sfire) begin
							nx.pins = entry.pat;
							nx.ne   = st_q.ne + 1'b1;
							nx.spc  = '0;
							nx.scc  = '0;
							if (NE_W'(st_q.ne + 1'b1) >= st_q.tlen) begin
								nx.step_on = 1'b0;
							end
						end
					end
				end
				MODE_START: begin
					if (st_q.active) begin
						nx.err = ERR_NOT_STOPPED;
					end else if (st_q.tlen == '0) begin
						nx.err = ERR_NO_DATA;
					end else begin
						// start fires the main timer at once
						ok         = 1'b1;
						nx.active  = 1'b1;
						nx.err     = ERR_OK;
						nx.plft    = cfg.cycle_limit - CFG_W'(cfg.cycle_limit != '0);
						nx.ne      = '0;
						nx.mpc     = '0;
						nx.mcc     = '0;
						nx.spc     = '0;
						nx.scc     = '0;
						nx.step_on = 1'b1;
						nx.pins    = cfg.idle_pins;
					end
				end
				MODE_STOP: begin
					if (!st_q.active) begin
						nx.err = ERR_NOT_STARTED;
					end else begin
						ok = 1'b1;
						nx = halt_st(st_q, ERR_OK, cfg.idle_pins);
					end
				end
				MODE_WRITE: begin
					if (st_q.active) begin
						nx.err = ERR_BUSY;
					end else if (NE_W'(item.entry_index) >= NE_W'(TABLE_DEPTH)) begin
						nx.err = ERR_OVERFLOW;
					end else begin
						ok        = 1'b1;
						req.wr_en = 1'b1;
						if (item.entry_last) begin
							nx.tlen = NE_W'(item.entry_index) + 1'b1;
						end
						nx.ne  = '0;
						nx.err = ERR_OK;
					end
				end
				MODE_RESET: begin
					ok      = 1'b1;
					req.clr = 1'b1;
					nx      = '0;
					nx.pins = cfg.idle_pins;
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
		// fetch the entry that becomes current after this edge
		req.rd_addr = nx.ne[IDX_W-1:0];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (acc) begin
			st_q <= nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= acc || (result_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			result_q.pins       <= nx.pins;
			result_q.running    <= nx.active;
			result_q.error_code <= nx.err;
			result_q.command_ok <= ok;
			result_q.step_index <= nx.ne;
		end
	end

endmodule

/* rtl/core/gpio_pattern_sequencer.sv */
// GPIO pattern sequencer. Items are commands (tick, start, stop, write table
// entry, reset); every item yields exactly one result with the pin pattern,
// running flag, last error, command status and next table index. One item is
// accepted per clock cycle, as the whole update runs between the sequencer
// state register and the result register; a held result does not block the
// next item unless the result side stalls. The transition table is a 64-entry
// RAM with registered read; the entry at the next index is fetched on every
// update, so the current entry's delay and pins are ready for the following
// item. Table entries have per-entry valid bits, so reset and the reset
// command clear the table without rewriting the RAM.
// Configuration registers (APB, byte address 4*i): cycle_limit, main_prescaler,
// main_count, idle_pins; write them only while no item is in flight.
module gpio_pattern_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  gps_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output gps_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gps_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import gps_pkg::*;

	cfg_t     cfg_q;
	tbl_req_t req;
	entry_t   entry;
	logic     wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_CYCLE_LIMIT:    cfg_q.cycle_limit    <= pwdata[CFG_W-1:0];
				REG_MAIN_PRESCALER: cfg_q.main_prescaler <= pwdata[CFG_W-1:0];
				REG_MAIN_COUNT:     cfg_q.main_count     <= pwdata[CFG_W-1:0];
				REG_IDLE_PINS:      cfg_q.idle_pins      <= pwdata[PIN_WIDTH-1:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_CYCLE_LIMIT:    prdata = 32'(cfg_q.cycle_limit);
			REG_MAIN_PRESCALER: prdata = 32'(cfg_q.main_prescaler);
			REG_MAIN_COUNT:     prdata = 32'(cfg_q.main_count);
			REG_IDLE_PINS:      prdata = 32'(cfg_q.idle_pins);
			default:            prdata = '0;
		endcase
	end

	gps_table u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.entry (entry)
	);

	gps_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg         (cfg_q),
		.entry       (entry),
		.req         (req)
	);

endmodule

/* dv/gpio_pattern_sequencer_tb.sv */
module gpio_pattern_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gps_pkg::*;

	localparam logic [2:0] MODE_SPARE_LO  = MODE_RESET + 3'd1;
	localparam logic [2:0] MODE_SPARE_HI  = 3'b111;
	localparam int         MAIN_TMR       = 0;
	localparam int         STEP_TMR       = 1;
	localparam int         ITEM_GOAL      = 1850;
	localparam int         PHASE_ITEMS    = 130;
	localparam int         LONG_HOLD      = 150;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         PRINT_CAP      = 40;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	item_t             cmd       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	result_t           rsp;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [31:0]       pwdata    = '0;
	logic [31:0]       prdata;
	logic              pready;

	// stimulus and scoreboard
	item_t   pending_cmds[$];
	result_t expected_outputs[$];
	int      items_queued  = 0;
	int      results_seen  = 0;
	int      mismatches    = 0;
	int      send_gap      = 0;
	int      stall_left    = 0;
	int      hold_requests = 0;
	int      holds_served  = 0;
	int      idle_cycles   = 0;
	bit      send_idle     = 1'b0;
	bit      rcv_idle      = 1'b0;

	// shadow of the sequencer state
	entry_t          tbl[TABLE_DEPTH];
	int              tbl_len;
	int              next_idx;
	bit              seq_active;
	logic [CFG_W-1:0] periods_left;
	logic [DELAY_WIDTH-1:0] tmr_pc[2];
	logic [DELAY_WIDTH-1:0] tmr_cc[2];
	bit              step_on;
	logic [PIN_WIDTH-1:0] pin_reg;
	err_t            last_err;
	cfg_t            cfg;

	function automatic void clear_seq();
		foreach (tbl[i]) tbl[i] = '0;
		tbl_len      = 0;
		next_idx     = 0;
		seq_active   = 1'b0;
		periods_left = '0;
		tmr_pc       = '{default: '0};
		tmr_cc       = '{default: '0};
		step_on      = 1'b0;
		last_err     = ERR_OK;
	endfunction

	function automatic void halt_seq(err_t e);
		step_on      = 1'b0;
		seq_active   = 1'b0;
		next_idx     = 0;
		periods_left = '0;
		tmr_pc       = '{default: '0};
		tmr_cc       = '{default: '0};
		last_err     = e;
		pin_reg      = cfg.idle_pins;
	endfunction

	// prescaler/count pair of one timer; 1 when its wait has run out
	function automatic bit stage_elapsed(int s, logic [DELAY_WIDTH-1:0] pre,
			logic [DELAY_WIDTH-1:0] cnt);
		if (tmr_pc[s] >= pre) begin
			tmr_pc[s] = '0;
			if (tmr_cc[s] >= cnt) begin
				tmr_cc[s] = '0;
				return 1'b1;
			end
			tmr_cc[s] = tmr_cc[s] + 1'b1;
		end else begin
			tmr_pc[s] = tmr_pc[s] + 1'b1;
		end
		return 1'b0;
	endfunction

	// main period boundary: halt if the table is not done, else pins to idle, rewind, check the cycle budget
	function automatic void period_start();
		if (next_idx < tbl_len) begin
			halt_seq(ERR_TOO_FAST);
			return;
		end
		pin_reg  = cfg.idle_pins;
		next_idx = 0;
		if (cfg.cycle_limit != '0) begin
			if (periods_left == '0) begin
				halt_seq(ERR_OK);
				return;
			end
			periods_left = periods_left - 1'b1;
		end
		tmr_pc[STEP_TMR] = '0;
		tmr_cc[STEP_TMR] = '0;
		step_on          = 1'b1;
	endfunction

	function automatic void apply_entry();
		if (next_idx >= tbl_len || next_idx >= TABLE_DEPTH) begin
			step_on = 1'b0;
			return;
		end
		pin_reg          = tbl[next_idx].pat;
		next_idx         = next_idx + 1;
		tmr_pc[STEP_TMR] = '0;
		tmr_cc[STEP_TMR] = '0;
		if (next_idx >= tbl_len)
			step_on = 1'b0;
	endfunction

	// main firing wins when both timers run out on the same tick
	function automatic void advance_tick();
		bit main_due;
		bit step_due;
		if (!seq_active)
			return;
		step_due = 1'b0;
		main_due = stage_elapsed(MAIN_TMR, cfg.main_prescaler, cfg.main_count);
		if (step_on && next_idx < tbl_len && next_idx < TABLE_DEPTH)
			step_due = stage_elapsed(STEP_TMR, tbl[next_idx].pre, tbl[next_idx].cnt);
		if (main_due)
			period_start();
		else if (step_due)
			apply_entry();
	endfunction

	function automatic result_t sequencer_step(item_t it);
		result_t r;
		logic    ok;
		ok = 1'b0;
		case (it.mode)
			MODE_TICK: begin
				advance_tick();
				ok = 1'b1;
			end
			MODE_START: begin
				if (seq_active) begin
					last_err = ERR_NOT_STOPPED;
				end else if (tbl_len == 0) begin
					last_err = ERR_NO_DATA;
				end else begin
					seq_active       = 1'b1;
					last_err         = ERR_OK;
					periods_left     = cfg.cycle_limit;
					next_idx         = tbl_len;
					tmr_pc[MAIN_TMR] = '0;
					tmr_cc[MAIN_TMR] = '0;
					step_on          = 1'b0;
					period_start();
					ok = 1'b1;
				end
			end
			MODE_STOP: begin
				if (!seq_active) begin
					last_err = ERR_NOT_STARTED;
				end else begin
					halt_seq(ERR_OK);
					ok = 1'b1;
				end
			end
			MODE_WRITE: begin
				if (seq_active) begin
					last_err = ERR_BUSY;
				end else if (int'(it.entry_index) >= TABLE_DEPTH) begin
					last_err = ERR_OVERFLOW;
				end else begin
					tbl[it.entry_index].pre = it.entry_prescaler;
					tbl[it.entry_index].cnt = it.entry_count;
					tbl[it.entry_index].pat = it.entry_pins;
					if (it.entry_last)
						tbl_len = int'(it.entry_index) + 1;
					next_idx = 0;
					last_err = ERR_OK;
					ok = 1'b1;
				end
			end
			MODE_RESET: begin
				clear_seq();
				pin_reg = cfg.idle_pins;
				ok = 1'b1;
			end
			default: ;
		endcase
		r.pins       = pin_reg;
		r.running    = seq_active;
		r.error_code = last_err;
		r.command_ok = ok;
		r.step_index = NE_W'(next_idx);
		return r;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic item_t make_cmd(logic [2:0] m);
		item_t it;
		it.mode            = m;
		it.entry_index     = IDX_W'($urandom);
		it.entry_prescaler = DELAY_WIDTH'($urandom);
		it.entry_count     = DELAY_WIDTH'($urandom);
		it.entry_pins      = PIN_WIDTH'($urandom);
		it.entry_last      = 1'($urandom);
		return it;
	endfunction

	function automatic item_t make_entry(int idx, logic [DELAY_WIDTH-1:0] pre,
			logic [DELAY_WIDTH-1:0] cnt, logic [PIN_WIDTH-1:0] pins, logic last);
		item_t it;
		it.mode            = MODE_WRITE;
		it.entry_index     = IDX_W'(idx);
		it.entry_prescaler = pre;
		it.entry_count     = cnt;
		it.entry_pins      = pins;
		it.entry_last      = last;
		return it;
	endfunction

	function automatic void enqueue(item_t it);
		pending_cmds.push_back(it);
		items_queued++;
	endfunction

	function automatic void enqueue_ticks(int n);
		repeat (n) enqueue(make_cmd(MODE_TICK));
	endfunction

	function automatic logic [CFG_W-1:0] cfg_value(int small_max);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return CFG_W'($urandom_range(0, small_max));
	endfunction

	gpio_pattern_sequencer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (cmd_valid),
		.item_stall   (cmd_stall),
		.item         (cmd),
		.result_valid (rsp_valid),
		.result_stall (rsp_stall),
		.result       (rsp),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// command driver; each accepted transfer is run through the shadow model
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall)
				expected_outputs.push_back(sequencer_step(cmd));
			if (!cmd_valid || !cmd_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					cmd       <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
					send_gap  = send_idle ? pick_gap() : 0;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			if (mismatches < PRINT_CAP)
				$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// result monitor and receiver backpressure
	always @(posedge clk) begin : rsp_mon
		result_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (expected_outputs.size() == 0) begin
					if (mismatches < PRINT_CAP)
						$error("result transfer with nothing expected: %p", rsp);
					mismatches++;
				end else begin
					want = expected_outputs.pop_front();
					check_field("pins", 32'(want.pins), 32'(rsp.pins));
					check_field("running", 32'(want.running), 32'(rsp.running));
					check_field("error_code", 32'(want.error_code), 32'(rsp.error_code));
					check_field("command_ok", 32'(want.command_ok), 32'(rsp.command_ok));
					check_field("step_index", 32'(want.step_index), 32'(rsp.step_index));
				end
			end
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				stall_left   = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (rcv_idle && $urandom_range(0, 5) == 0) begin
				stall_left = pick_gap();
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("gpio_pattern_sequencer: mismatch");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("pready", 32'(1'b1), 32'(pready));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_CYCLE_LIMIT:    cfg.cycle_limit    = val;
			REG_MAIN_PRESCALER: cfg.main_prescaler = val;
			REG_MAIN_COUNT:     cfg.main_count     = val;
			REG_IDLE_PINS:      cfg.idle_pins      = val;
			default: ;
		endcase
		// readback of the register just written
		@(posedge clk);
		check_field("prdata", 32'(val), prdata);
	endtask

	// every queued command has produced its result
	task automatic wait_idle();
		while (results_seen != items_queued)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_phase_config(int phase);
		if (phase == 1) begin
			write_reg(REG_CYCLE_LIMIT, '1);
			write_reg(REG_MAIN_PRESCALER, '1);
			write_reg(REG_MAIN_COUNT, '1);
			write_reg(REG_IDLE_PINS, '1);
		end else if (phase == 4) begin
			write_reg(REG_CYCLE_LIMIT, '0);
			write_reg(REG_MAIN_PRESCALER, '0);
			write_reg(REG_MAIN_COUNT, '0);
			write_reg(REG_IDLE_PINS, '0);
		end else begin
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_CYCLE_LIMIT, cfg_value(6));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_MAIN_PRESCALER, cfg_value(3));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_MAIN_COUNT, cfg_value(40));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_IDLE_PINS, cfg_value(16'hFFFF));
		end
	endtask

	// mostly complete program/start/run sequences, the rest random commands
	task automatic queue_random_phase(int budget);
		int stop_at;
		int k;
		int r;
		stop_at = items_queued + budget;
		while (items_queued < stop_at) begin
			if ($urandom_range(0, 9) < 7) begin
				enqueue(make_cmd(MODE_STOP));
				if ($urandom_range(0, 3) == 0)
					enqueue(make_cmd(MODE_RESET));
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++)
					enqueue(make_entry(i, DELAY_WIDTH'($urandom_range(0, 3)),
						DELAY_WIDTH'($urandom_range(0, 6)), PIN_WIDTH'($urandom),
						i == k - 1));
				enqueue(make_cmd(MODE_START));
				enqueue_ticks($urandom_range(8, 60));
				if ($urandom_range(0, 3) == 0)
					enqueue(make_cmd(MODE_STOP));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					r = $urandom_range(0, 99);
					if (r < 30)
						enqueue(make_cmd(MODE_TICK));
					else if (r < 45)
						enqueue(make_cmd(MODE_START));
					else if (r < 60)
						enqueue(make_cmd(MODE_STOP));
					else if (r < 85)
						enqueue(make_cmd(MODE_WRITE));
					else if (r < 95)
						enqueue(make_cmd(MODE_RESET));
					else
						enqueue(make_cmd(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))));
				end
			end
		end
	endtask

	initial begin
		int phase;
		clear_seq();
		pin_reg = '0;
		cfg     = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// error paths with reset register values (main period of one tick)
		enqueue(make_cmd(MODE_STOP));
		enqueue(make_cmd(MODE_START));
		for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
			enqueue(make_cmd(3'(m)));
		enqueue(make_entry(0, '0, '0, '1, 1'b0));
		enqueue(make_cmd(MODE_START));
		enqueue(make_entry(TABLE_DEPTH - 1, '1, '1, '0, 1'b1));
		enqueue(make_entry(1, '0, 16'd1, 16'hA5A5, 1'b1));
		enqueue(make_cmd(MODE_START));
		enqueue(make_cmd(MODE_START));
		enqueue(make_cmd(MODE_WRITE));
		enqueue(make_cmd(MODE_TICK));
		enqueue(make_cmd(MODE_RESET));
		wait_idle();

		// two-tick period, two periods allowed, then main and step due together
		write_reg(REG_CYCLE_LIMIT, 16'd2);
		write_reg(REG_MAIN_PRESCALER, '0);
		write_reg(REG_MAIN_COUNT, 16'd1);
		write_reg(REG_IDLE_PINS, 16'hC3C3);
		enqueue(make_entry(0, '0, '0, 16'h1234, 1'b1));
		enqueue(make_cmd(MODE_START));
		enqueue_ticks(5);
		enqueue(make_cmd(MODE_STOP));
		enqueue(make_entry(0, '0, 16'd1, 16'h5A5A, 1'b1));
		enqueue(make_cmd(MODE_START));
		enqueue_ticks(2);
		wait_idle();

		phase = 0;
		while (items_queued < ITEM_GOAL) begin
			set_phase_config(phase);
			send_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
			rcv_idle  = (phase != 0) && ($urandom_range(0, 3) != 0);
			if (phase == 2)
				hold_requests++;
			queue_random_phase(PHASE_ITEMS);
			wait_idle();
			phase++;
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("gpio_pattern_sequencer: match");
		else
			$display("gpio_pattern_sequencer: mismatch");
		$finish;
	end

endmodule

/* files.f */
rtl/core/gps_pkg.sv
rtl/core/gps_ram.sv
rtl/core/gps_table.sv
rtl/core/gps_core.sv
rtl/core/gpio_pattern_sequencer.sv
dv/gpio_pattern_sequencer_tb.sv
